@@ sv/assert_macros.svh @@
// Assertion macros shared by the fractional feedback delay modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define ASSERT_DEF(label, prop) `ASSERT_CLK(label, clk_i, rst_ni, prop)
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_DEF(label, prop)
`endif
`endif

@@ sv/ffd_pkg.sv @@
// Package with widths, state encoding and control types of the fractional feedback delay.
package ffd_pkg;

  localparam int DefDepth = 16384;
  localparam int SampleW  = 16;
  localparam int DelayW   = 22;
  localparam int FracW    = 8;
  localparam int GainW    = 16;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_NEW,
    S_RD_OLD,
    S_MUL,
    S_SUM,
    S_FB,
    S_WR
  } ffd_state_e;

  typedef struct packed {
    logic take_in;
    logic issue_new;
    logic issue_old;
    logic mul;
    logic sum;
    logic load_out;
    logic write;
  } ffd_cmd_t;

  typedef struct packed {
    logic out_blocked;
  } ffd_status_t;

endpackage

@@ sv/ffd_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module ffd_ram #(
  parameter int Width = 16,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/ffd_ctrl.sv @@
// Sequencer that steps one sample beat through reads, interpolation, feedback and write.
`include "assert_macros.svh"

module ffd_ctrl
  import ffd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  ffd_status_t status_i,
  output ffd_cmd_t    cmd_o
);

  ffd_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.take_in = 1'b1;
          state_d       = S_RD_NEW;
        end
      end
      S_RD_NEW: begin
        cmd_o.issue_new = 1'b1;
        state_d         = S_RD_OLD;
      end
      S_RD_OLD: begin
        cmd_o.issue_old = 1'b1;
        state_d         = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_FB;
      end
      S_FB: begin
        if (!status_i.out_blocked) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_WR;
        end
      end
      S_WR: begin
        cmd_o.write = 1'b1;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  `ASSERT_DEF(a_cmd_onehot, $onehot0(cmd_o))
  `ASSERT_DEF(a_take_starts_reads, cmd_o.take_in |=> cmd_o.issue_new)
  `ASSERT_DEF(a_write_follows_load, cmd_o.load_out |=> cmd_o.write)

endmodule

@@ sv/ffd_datapath.sv @@
// Datapath with the delay memory, tap addressing, interpolation, feedback and output register.
`include "assert_macros.svh"

module ffd_datapath
  import ffd_pkg::*;
#(
  parameter int Depth = DefDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ffd_cmd_t                   cmd_i,
  output ffd_status_t                status_o,
  input  logic signed [SampleW-1:0]  in_sample_i,
  input  logic        [DelayW-1:0]   delay_amount_i,
  input  logic                       cfg_we_i,
  input  logic signed [GainW-1:0]    cfg_wdata_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [SampleW-1:0]  out_sample_o
);

  localparam int AW        = $clog2(Depth);
  localparam int DW        = $clog2(Depth + 1);
  localparam int CmpW      = (DelayW > DW + FracW) ? DelayW : DW + FracW;
  localparam int ProdW     = SampleW + FracW + 2;
  localparam int AccW      = ProdW + 1;
  localparam int Half      = 2 ** (FracW - 1);
  localparam int FbW       = SampleW + GainW;
  localparam int GainFrac  = GainW - 1;
  localparam int FbHalf    = 2 ** (GainFrac - 1);
  localparam int SampleMax = 2 ** (SampleW - 1) - 1;
  localparam int SampleMin = -(2 ** (SampleW - 1));
  localparam logic [CmpW-1:0] Limit = CmpW'(Depth) << FracW;

  function automatic logic signed [SampleW-1:0] sat_sample(input logic signed [31:0] v);
    if (v > SampleMax) begin
      return SampleW'(SampleMax);
    end else if (v < SampleMin) begin
      return SampleW'(SampleMin);
    end else begin
      return v[SampleW-1:0];
    end
  endfunction

  logic signed [GainW-1:0]   gain_q;
  logic signed [SampleW-1:0] sample_q;
  logic        [DW-1:0]      d_q;
  logic        [FracW-1:0]   f_q;
  logic        [AW-1:0]      wi_q;
  logic                      wrapped_q;
  logic        [AW-1:0]      rd_q;
  logic                      vnew_q, vold_q;
  logic signed [SampleW-1:0] a_q;
  logic signed [ProdW-1:0]   pa_q, pb_q;
  logic signed [SampleW-1:0] y_q;
  logic signed [FbW-1:0]     prod_q;
  logic                      out_valid_q;
  logic signed [SampleW-1:0] out_sample_q;

  logic        [CmpW-1:0]    t_ext, t_clamp;
  logic        [DW:0]        wi_x, d_x, diff, rd_full;
  logic        [AW-1:0]      rd_new, rd_old, raddr;
  logic        [SampleW-1:0] rdata;
  logic signed [SampleW-1:0] rd_word, b_word;
  logic        [FracW:0]     wa;
  logic signed [ProdW-1:0]   pa, pb;
  logic signed [AccW-1:0]    acc, y_shift;
  logic signed [31:0]        fb, stored_full;
  logic signed [SampleW-1:0] stored;

  assign t_ext   = CmpW'(delay_amount_i);
  assign t_clamp = (t_ext > Limit) ? Limit : t_ext;

  assign wi_x    = (DW + 1)'(wi_q);
  assign d_x     = (DW + 1)'(d_q);
  assign diff    = wi_x - d_x;
  assign rd_full = (wi_x >= d_x) ? diff : diff + (DW + 1)'(Depth);
  assign rd_new  = rd_full[AW-1:0];
  assign rd_old  = (rd_q == '0) ? AW'(Depth - 1) : rd_q - AW'(1);
  assign raddr   = cmd_i.issue_new ? rd_new : rd_old;

  ffd_ram #(
    .Width(SampleW),
    .Depth(Depth)
  ) u_line (
    .clk_i  (clk_i),
    .we_i   (cmd_i.write),
    .waddr_i(wi_q),
    .wdata_i(stored),
    .re_i   (cmd_i.issue_new | cmd_i.issue_old),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Entries not yet written since reset read as zero.
  assign rd_word = vnew_q ? $signed(rdata) : '0;
  assign b_word  = vold_q ? $signed(rdata) : '0;

  assign wa = (FracW + 1)'(2 ** FracW) - {1'b0, f_q};
  assign pa = a_q * $signed({1'b0, wa});
  assign pb = b_word * $signed({2'b00, f_q});

  assign acc     = AccW'(pa_q) + AccW'(pb_q) + AccW'(Half);
  assign y_shift = acc >>> FracW;

  assign fb          = (32'(prod_q) + 32'(FbHalf)) >>> GainFrac;
  assign stored_full = 32'(sample_q) + fb;
  assign stored      = sat_sample(stored_full);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q    <= '0;
      wi_q      <= '0;
      wrapped_q <= 1'b0;
      vnew_q    <= 1'b0;
      vold_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        gain_q <= cfg_wdata_i;
      end
      if (cmd_i.issue_new) begin
        vnew_q <= wrapped_q || (rd_new < wi_q);
      end
      if (cmd_i.issue_old) begin
        vold_q <= wrapped_q || (rd_old < wi_q);
      end
      if (cmd_i.write) begin
        if (wi_q == AW'(Depth - 1)) begin
          wi_q      <= '0;
          wrapped_q <= 1'b1;
        end else begin
          wi_q <= wi_q + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_in) begin
      sample_q <= in_sample_i;
      d_q      <= t_clamp[FracW +: DW];
      f_q      <= t_clamp[FracW-1:0];
    end
    if (cmd_i.issue_new) begin
      rd_q <= rd_new;
    end
    if (cmd_i.issue_old) begin
      a_q <= rd_word;
    end
    if (cmd_i.mul) begin
      pa_q <= pa;
      pb_q <= pb;
    end
    if (cmd_i.sum) begin
      y_q <= sat_sample(32'(y_shift));
    end
    if (cmd_i.load_out) begin
      prod_q       <= y_q * gain_q;
      out_sample_q <= y_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.out_blocked = out_valid_q && out_stall_i;
  assign out_valid_o          = out_valid_q;
  assign out_sample_o         = out_sample_q;

  `ASSERT_DEF(a_wi_in_range, wi_q <= AW'(Depth - 1))
  `ASSERT_DEF(a_wrap_at_zero, $rose(wrapped_q) |-> wi_q == '0)
  `ASSERT_DEF(a_no_overwrite, cmd_i.load_out |-> !(out_valid_q && out_stall_i))

endmodule

@@ sv/fractional_feedback_delay.sv @@
// Top level of the fractional feedback delay: sequencer plus datapath.
//
// Usage: one input beat carries an in_sample_i (signed Q1.15) and a
// delay_amount_i (unsigned samples with 8 fraction bits, clamped to Depth).
// A beat is taken at a rising edge with in_valid_i high and in_stall_o low,
// and every input beat yields exactly one output beat on out_sample_o, taken
// at an edge with out_valid_o high and out_stall_i low.
// The output is the linear blend of the stored samples at the integer
// delay and one sample older; the input plus the output times feedback_gain
// is written back. The user must write the gain through cfg_we_i/cfg_wdata_i
// only while the block is idle; the block itself does not enforce this.
// A beat steps through its take, two reads on the single read port of the
// delay memory, the interpolation multiply and sum, the feedback multiply
// and the write; a new beat is taken only after that write.
// A stalled output holds its beat; the next result waits in the sequencer
// until the output register drains, so the input stalls as well.
// Reset clears the gain and the write index at once. There is no clearing
// pass: entries of the delay memory not yet written since reset read as zero.
module fractional_feedback_delay
  import ffd_pkg::*;
#(
  parameter int Depth = DefDepth
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [SampleW-1:0] in_sample_i,
  input  logic        [DelayW-1:0]  delay_amount_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [SampleW-1:0] out_sample_o,
  input  logic                      cfg_we_i,
  input  logic signed [GainW-1:0]   cfg_wdata_i
);

  ffd_cmd_t    cmd;
  ffd_status_t status;

  ffd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  ffd_datapath #(
    .Depth(Depth)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .in_sample_i   (in_sample_i),
    .delay_amount_i(delay_amount_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_sample_o  (out_sample_o)
  );

endmodule

@@ test/fractional_feedback_delay_tb.sv @@
// Self-checking testbench for the fractional feedback delay with its own delay line model.
`timescale 1ns / 1ps

module fractional_feedback_delay_tb;
  import ffd_pkg::*;

  localparam int Depth      = DefDepth;
  localparam int CycleLimit = 600000;
  localparam int PhaseItems = 150;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic signed [SampleW-1:0] in_sample_i;
  logic        [DelayW-1:0]  delay_amount_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic signed [SampleW-1:0] out_sample_o;
  logic                      cfg_we_i;
  logic signed [GainW-1:0]   cfg_wdata_i;

  logic signed [SampleW-1:0] line_mem [Depth];
  int unsigned               wr_ptr;
  logic signed [GainW-1:0]   gain_q;
  logic signed [SampleW-1:0] pending_out_samples [$];

  int  err_count;
  int  cycle_count;
  int  stall_left;
  bit  sender_idle;
  bit  sink_idle;

  fractional_feedback_delay #(
    .Depth(Depth)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_sample_i    (in_sample_i),
    .delay_amount_i (delay_amount_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_sample_o   (out_sample_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic longint sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic logic signed [SampleW-1:0] delay_line_step(
    logic signed [SampleW-1:0] smp,
    logic [DelayW-1:0] dly
  );
    longint t, d, f, rd, rd_old, a, b, y, p, sum;
    t = dly;
    if (t > longint'(Depth) * 256) t = longint'(Depth) * 256;
    d = t >> FracW;
    f = t & 255;
    rd = (longint'(wr_ptr) - d + Depth) % Depth;
    rd_old = (rd + Depth - 1) % Depth;
    a = line_mem[rd];
    b = line_mem[rd_old];
    y = sat16((a * (256 - f) + b * f + 128) >>> 8);
    p = (y * longint'(gain_q) + 16384) >>> 15;
    sum = sat16(longint'(smp) + p);
    line_mem[wr_ptr] = sum[SampleW-1:0];
    wr_ptr = (wr_ptr + 1) % Depth;
    return y[SampleW-1:0];
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [DelayW-1:0] pick_delay();
    case ($urandom_range(0, 9))
      0, 1: return DelayW'($urandom);
      2: return DelayW'($urandom_range(0, 255));
      3: return DelayW'($urandom_range(0, 63) << FracW);
      4: return {14'h3FFF, 8'(($urandom_range(0, 255)))};
      default: return DelayW'($urandom_range(0, 64 * 256 - 1));
    endcase
  endfunction

  function automatic logic signed [SampleW-1:0] pick_sample();
    case ($urandom_range(0, 19))
      0: return 16'sh7FFF;
      1: return -16'sh8000;
      2: return 16'sh0000;
      3: return -16'sh0001;
      default: return SampleW'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    err_count++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_out_samples.size() == 0) begin
        report_mismatch($sformatf("unexpected out_sample %0d", out_sample_o));
      end else begin
        if (out_sample_o !== pending_out_samples[0]) begin
          report_mismatch($sformatf("out_sample %0d, expected %0d",
                                    out_sample_o, pending_out_samples[0]));
        end
        void'(pending_out_samples.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
      if (sink_idle && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  task automatic send_sample(input logic signed [SampleW-1:0] smp,
                             input logic [DelayW-1:0] dly);
    int gap;
    in_valid_i     <= 1'b1;
    in_sample_i    <= smp;
    delay_amount_i <= dly;
    do @(posedge clk_i); while (in_stall_o);
    pending_out_samples.push_back(delay_line_step(smp, dly));
    gap = sender_idle ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_block();
    in_valid_i <= 1'b0;
    while (pending_out_samples.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_gain(input logic signed [GainW-1:0] g);
    drain_block();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= g;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    gain_q = g;
  endtask

  task automatic test_tap_positions();
    sender_idle = 1'b1;
    sink_idle   = 1'b1;
    write_gain(16'sh0000);
    send_sample(16'sh7FFF, 22'd0);
    send_sample(-16'sh8000, 22'd0);
    send_sample(16'sh3039, 22'd256);
    send_sample(-16'sh0001, 22'd128);
    send_sample(16'sh0064, 22'd255);
    send_sample(16'sh0007, 22'd1);
    send_sample(16'sh0000, 22'h3FFFFF);
    send_sample(-16'sh8000, 22'h3FFF00);
    send_sample(16'sh1234, 22'd513);
  endtask

  task automatic test_feedback_saturation();
    write_gain(16'sh7FFF);
    repeat (4) send_sample(16'sh7FFF, 22'd256);
    write_gain(-16'sh8000);
    send_sample(-16'sh8000, 22'd256);
    send_sample(16'sh7FFF, 22'd256);
    send_sample(-16'sh8000, 22'd256);
    send_sample(-16'sh8000, 22'd384);
  endtask

  task automatic test_random_phases();
    logic signed [GainW-1:0] gains [5];
    gains[0] = -16'sh8000;
    gains[1] = 16'sh7FFF;
    gains[2] = GainW'($urandom);
    gains[3] = 16'sh0000;
    gains[4] = GainW'($urandom);
    for (int ph = 0; ph < 5; ph++) begin
      write_gain(gains[ph]);
      sender_idle = (ph != 1) && (ph != 4);
      sink_idle   = (ph != 1) && (ph != 3);
      repeat (PhaseItems) send_sample(pick_sample(), pick_delay());
    end
  endtask

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_sample_i    = '0;
    delay_amount_i = '0;
    out_stall_i    = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    err_count      = 0;
    cycle_count    = 0;
    stall_left     = 0;
    sender_idle    = 1'b0;
    sink_idle      = 1'b0;
    wr_ptr         = 0;
    gain_q         = '0;
    for (int i = 0; i < Depth; i++) line_mem[i] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_tap_positions();
    test_feedback_saturation();
    test_random_phases();
    drain_block();
    repeat (10) @(posedge clk_i);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
